FILE: src/sndfifo_pkg.sv
// ----------------------------------------------------------------------------
// sndfifo_pkg
// Shared constants for the sound control block with two sample FIFOs.
// ----------------------------------------------------------------------------
`default_nettype none

package sndfifo_pkg;

    localparam int DATA_W             = 8;
    localparam int DEFAULT_FIFO_DEPTH = 32;

    localparam logic [1:0] OP_CTRL_WR  = 2'd0;
    localparam logic [1:0] OP_CTRL_RD  = 2'd1;
    localparam logic [1:0] OP_FIFO_PUSH = 2'd2;
    localparam logic [1:0] OP_FIFO_POP  = 2'd3;

    localparam logic CTRL_BYTE0 = 1'b0;
    localparam logic CTRL_BYTE1 = 1'b1;

endpackage

`default_nettype wire

FILE: src/sndfifo_ram.sv
// ----------------------------------------------------------------------------
// sndfifo_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sndfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/sound_control_with_dual_fifo.sv
// ----------------------------------------------------------------------------
// sound_control_with_dual_fifo
// Two-byte sound control register with two sample FIFOs kept in one RAM.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | s_valid s_ready s_op s_target s_data    | in
//   result  | m_valid m_ready m_read_data m_level_a/b | out
//
// A pop from a non-empty FIFO waits in ST_READ for the registered read
// port of the sample RAM; other transactions register their result
// directly. Reset clears the control bits and the FIFO pointers and
// counts; the RAM itself is not cleared. A new transaction is taken in
// ST_IDLE while the result register is empty or drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_control_with_dual_fifo #(
    parameter int FIFO_DEPTH = sndfifo_pkg::DEFAULT_FIFO_DEPTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [1:0]                            s_op,
    input  wire logic                                  s_target,
    input  wire logic [sndfifo_pkg::DATA_W-1:0]        s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic      [sndfifo_pkg::DATA_W-1:0]        m_read_data,
    output logic      [$clog2(FIFO_DEPTH+1)-1:0]       m_level_a,
    output logic      [$clog2(FIFO_DEPTH+1)-1:0]       m_level_b
);

    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W    = PTR_W + 1;
    localparam int RAM_DEPTH = 2 * (2 ** PTR_W);
    localparam int DW        = sndfifo_pkg::DATA_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    function automatic ptr_t advance(input ptr_t p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic          state_reg, state_next;
    logic [1:0]    psg_vol_reg, psg_vol_next;
    logic [1:0]    dma_vol_reg, dma_vol_next;
    logic [2:0]    chan_a_reg, chan_a_next;
    logic [2:0]    chan_b_reg, chan_b_next;
    ptr_t          head_reg [2];
    ptr_t          head_next [2];
    ptr_t          tail_reg [2];
    ptr_t          tail_next [2];
    cnt_t          count_reg [2];
    cnt_t          count_next [2];
    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] m_read_data_reg, m_read_data_next;
    cnt_t          m_level_a_reg, m_level_a_next;
    cnt_t          m_level_b_reg, m_level_b_next;

    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DW-1:0]     ram_rdata;
    logic [DW-1:0]     rd_value;
    logic              pop_wait;

    assign s_ready     = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_level_a   = m_level_a_reg;
    assign m_level_b   = m_level_b_reg;

    always_comb begin
        state_next       = state_reg;
        psg_vol_next     = psg_vol_reg;
        dma_vol_next     = dma_vol_reg;
        chan_a_next      = chan_a_reg;
        chan_b_next      = chan_b_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_read_data_next = m_read_data_reg;
        m_level_a_next   = m_level_a_reg;
        m_level_b_next   = m_level_b_reg;
        ram_we           = 1'b0;
        ram_waddr        = {s_target, tail_reg[s_target]};
        ram_re           = 1'b0;
        ram_raddr        = {s_target, head_reg[s_target]};
        rd_value         = '0;
        pop_wait         = 1'b0;

        if (accept) begin
            unique case (s_op)
                sndfifo_pkg::OP_CTRL_WR: begin
                    if (s_target == sndfifo_pkg::CTRL_BYTE0) begin
                        psg_vol_next = s_data[1:0];
                        dma_vol_next = s_data[3:2];
                    end else begin
                        chan_a_next = s_data[2:0];
                        chan_b_next = s_data[6:4];
                        if (s_data[3]) begin
                            head_next[0]  = '0;
                            tail_next[0]  = '0;
                            count_next[0] = '0;
                        end
                        if (s_data[7]) begin
                            head_next[1]  = '0;
                            tail_next[1]  = '0;
                            count_next[1] = '0;
                        end
                    end
                end
                sndfifo_pkg::OP_CTRL_RD: begin
                    if (s_target == sndfifo_pkg::CTRL_BYTE0) begin
                        rd_value = {4'b0000, dma_vol_reg, psg_vol_reg};
                    end else begin
                        rd_value = {1'b0, chan_b_reg, 1'b0, chan_a_reg};
                    end
                end
                sndfifo_pkg::OP_FIFO_PUSH: begin
                    if (count_reg[s_target] != CNT_W'(FIFO_DEPTH)) begin
                        ram_we                = 1'b1;
                        tail_next[s_target]   = advance(tail_reg[s_target]);
                        count_next[s_target]  = count_reg[s_target] + 1'b1;
                    end
                end
                sndfifo_pkg::OP_FIFO_POP: begin
                    if (count_reg[s_target] != '0) begin
                        ram_re                = 1'b1;
                        pop_wait              = 1'b1;
                        head_next[s_target]   = advance(head_reg[s_target]);
                        count_next[s_target]  = count_reg[s_target] - 1'b1;
                    end
                end
                default: begin
                end
            endcase

            m_level_a_next   = count_next[0];
            m_level_b_next   = count_next[1];
            m_read_data_next = rd_value;
            m_valid_next     = !pop_wait;
            state_next       = pop_wait ? ST_READ : ST_IDLE;
        end else if (state_reg == ST_READ) begin
            m_read_data_next = ram_rdata;
            m_valid_next     = 1'b1;
            state_next       = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            psg_vol_reg <= '0;
            dma_vol_reg <= '0;
            chan_a_reg  <= '0;
            chan_b_reg  <= '0;
            head_reg    <= '{default: '0};
            tail_reg    <= '{default: '0};
            count_reg   <= '{default: '0};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            psg_vol_reg <= psg_vol_next;
            dma_vol_reg <= dma_vol_next;
            chan_a_reg  <= chan_a_next;
            chan_b_reg  <= chan_b_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_read_data_reg <= m_read_data_next;
        m_level_a_reg   <= m_level_a_next;
        m_level_b_reg   <= m_level_b_next;
    end

    sndfifo_ram #(
        .WIDTH (DW),
        .DEPTH (RAM_DEPTH)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

FILE: src/sndfifo_chk.sv
// ----------------------------------------------------------------------------
// sndfifo_chk
// Port-level checks for the sound control block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sndfifo_chk #(
    parameter int FIFO_DEPTH = sndfifo_pkg::DEFAULT_FIFO_DEPTH
) (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic [sndfifo_pkg::DATA_W-1:0]      m_read_data,
    input wire logic [$clog2(FIFO_DEPTH+1)-1:0]     m_level_a,
    input wire logic [$clog2(FIFO_DEPTH+1)-1:0]     m_level_b
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level_a <= CNT_W'(FIFO_DEPTH)) && (m_level_b <= CNT_W'(FIFO_DEPTH)))
        else $error("fifo level above depth");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_level_a) && $stable(m_level_b))
        else $error("stalled result changed");

    a_one_result_per_transaction: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !(m_valid && m_ready) |=> !s_ready || m_valid)
        else $error("transaction accepted with no result pending");

endmodule

bind sound_control_with_dual_fifo sndfifo_chk #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_sndfifo_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_level_a   (m_level_a),
    .m_level_b   (m_level_b)
);

`default_nettype wire
